// File: rtl/finite_difference_gradient_stencil_defines.svh
// Assertion macros shared by the gradient stencil RTL.
`ifndef FINITE_DIFFERENCE_GRADIENT_STENCIL_DEFINES_SVH
`define FINITE_DIFFERENCE_GRADIENT_STENCIL_DEFINES_SVH

// cond must never hold while out of reset
`define FDG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define FDG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/fdg_pkg.sv
// Types, constants and rounding helper for the gradient stencil.
package fdg_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int NUM_COLS_W  = 11;
    localparam int NUM_ROWS_W  = 16;
    localparam int INV_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int SAMPLE_W    = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int LINE_W      = 2 * SAMPLE_W;
    localparam int N_TERMS     = 10;
    localparam int OUT_W       = N_TERMS * SAMPLE_W;
    localparam int DIFF_W      = SAMPLE_W + 2;
    localparam int PROD_W      = DIFF_W + INV_W - FRAC_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = NUM_COLS_W'(1024);
    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = NUM_ROWS_W'(1024);
    localparam logic [INV_W-1:0]      INV_RST      = INV_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLS,
        REG_NUM_ROWS,
        REG_INV_DX,
        REG_INV_DY
    } fdg_reg_t;

    // 3x3 neighborhood, [row][col], row 2 / col 2 newest
    typedef logic [2:0][2:0][SAMPLE_W-1:0] fdg_win_t;

    typedef struct packed {
        logic     last;
        fdg_win_t win;
    } fdg_item_t;

    // terms: dx_fwd, dx_bwd, dy_fwd, dy_bwd, dx_c, dy_c, dx_up, dx_lo, dy_rt, dy_lf
    localparam logic [N_TERMS-1:0] TERM_USE_DY = 10'b1100101100;
    localparam logic [N_TERMS-1:0][1:0] TERM_K = {
        2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0
    };

    function automatic logic signed [DIFF_W-1:0] fdg_sext(input logic [SAMPLE_W-1:0] x);
        return {{(DIFF_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
    endfunction

    // shift by k, floor toward minus infinity, saturate to 32 bits signed
    function automatic logic [SAMPLE_W-1:0] fdg_round_sat(
        input logic [ACC_W-1:0] acc,
        input logic             sticky_lo,
        input logic             neg,
        input logic [1:0]       k
    );
        logic [ACC_W-1:0] r;
        logic             sticky;
        logic [ACC_W-1:0] rr;
        logic [SAMPLE_W-1:0] res;
        case (k)
            2'd0: begin
                r      = acc;
                sticky = sticky_lo;
            end
            2'd1: begin
                r      = acc >> 1;
                sticky = sticky_lo | acc[0];
            end
            default: begin
                r      = acc >> 2;
                sticky = sticky_lo | (acc[1:0] != 2'b00);
            end
        endcase
        rr = r + ACC_W'(sticky);
        if (!neg) begin
            res = (r > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r[SAMPLE_W-1:0];
        end else begin
            res = (rr > ACC_W'(32'h8000_0000)) ? 32'h8000_0000
                                                : (SAMPLE_W'(0) - rr[SAMPLE_W-1:0]);
        end
        return res;
    endfunction

endpackage

// File: rtl/fdg_ram.sv
// Generic simple dual-port RAM with registered read.
module fdg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fdg_front.sv
// Front end: raster counters, line RAM, 3x3 window and interior classification.
`include "finite_difference_gradient_stencil_defines.svh"
module fdg_front
    import fdg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [NUM_COLS_W-1:0] num_cols,
    input  logic [NUM_ROWS_W-1:0] num_rows,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,
    input  logic [Q_CNT_W-1:0]    q_count,
    output logic                  push_valid,
    output fdg_item_t             push_item
);

    logic [COL_W-1:0]      clr_addr_reg;
    logic                  clr_done_reg;
    logic [COL_W-1:0]      col_count_reg, col_count_next;
    logic [NUM_ROWS_W-1:0] row_count_reg, row_count_next;
    logic                  s1_valid_reg;
    logic [SAMPLE_W-1:0]   s1_sample_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic                  s1_interior_reg;
    logic                  s1_last_reg;
    fdg_win_t              win_reg, win_next;

    logic [NUM_COLS_W-1:0] nc;
    logic [NUM_ROWS_W-1:0] nr;
    logic                  accept;
    logic                  c_wrap;
    logic [COL_W-1:0]      c_cur;
    logic [NUM_ROWS_W:0]   r_tmp;
    logic [NUM_ROWS_W-1:0] r_cur;
    logic [NUM_COLS_W-1:0] c_inc;
    logic [NUM_ROWS_W:0]   r_inc;
    logic                  interior;
    logic                  last;
    logic                  ram_we;
    logic [COL_W-1:0]      ram_waddr;
    logic [LINE_W-1:0]     ram_wdata;
    logic [LINE_W-1:0]     ram_rdata;
    logic [Q_CNT_W-1:0]    pending;

    always_comb begin
        if (num_cols < NUM_COLS_W'(3)) begin
            nc = NUM_COLS_W'(3);
        end else if (num_cols > NUM_COLS_W'(MAX_COLS)) begin
            nc = NUM_COLS_W'(MAX_COLS);
        end else begin
            nc = num_cols;
        end
        nr = (num_rows < NUM_ROWS_W'(3)) ? NUM_ROWS_W'(3) : num_rows;
    end

    assign pending  = q_count + Q_CNT_W'(s1_valid_reg);
    assign s_tready = clr_done_reg && (pending < Q_CNT_W'(Q_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // raster position, re-wrapped in case the size shrank while idle
    always_comb begin
        c_wrap = NUM_COLS_W'(col_count_reg) >= nc;
        c_cur  = c_wrap ? '0 : col_count_reg;
        r_tmp  = c_wrap ? ({1'b0, row_count_reg} + (NUM_ROWS_W+1)'(1)) : {1'b0, row_count_reg};
        r_cur  = (r_tmp >= {1'b0, nr}) ? '0 : r_tmp[NUM_ROWS_W-1:0];
        c_inc  = NUM_COLS_W'(c_cur) + NUM_COLS_W'(1);
        r_inc  = {1'b0, r_cur} + (NUM_ROWS_W+1)'(1);
        if (c_inc >= nc) begin
            col_count_next = '0;
            row_count_next = (r_inc >= {1'b0, nr}) ? '0 : r_inc[NUM_ROWS_W-1:0];
        end else begin
            col_count_next = c_inc[COL_W-1:0];
            row_count_next = r_cur;
        end
        interior = (r_cur >= NUM_ROWS_W'(2)) && (c_cur >= COL_W'(2));
        last     = (r_cur == nr - NUM_ROWS_W'(1)) && (NUM_COLS_W'(c_cur) == nc - NUM_COLS_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            clr_done_reg  <= 1'b0;
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            win_reg       <= '0;
        end else begin
            if (!clr_done_reg) begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_W'(MAX_COLS - 1)) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (accept) begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg   <= s_tdata;
            s1_col_reg      <= c_cur;
            s1_interior_reg <= interior;
            s1_last_reg     <= last;
        end
    end

    // ram word: previous row in the upper half, the row before it in the lower
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = ram_rdata[SAMPLE_W-1:0];
        win_next[1][2] = ram_rdata[LINE_W-1:SAMPLE_W];
        win_next[2][2] = s1_sample_reg;
    end

    assign ram_we    = !clr_done_reg || s1_valid_reg;
    assign ram_waddr = clr_done_reg ? s1_col_reg : clr_addr_reg;
    assign ram_wdata = clr_done_reg ? {s1_sample_reg, ram_rdata[LINE_W-1:SAMPLE_W]} : '0;

    fdg_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_COLS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    assign push_valid    = s1_valid_reg && s1_interior_reg;
    assign push_item.last = s1_last_reg;
    assign push_item.win  = win_next;

    `FDG_ASSERT_IMPLY(a_no_rw_collision, aclk, aresetn, accept && s1_valid_reg, c_cur != s1_col_reg, "line RAM read and write hit the same column")
    `FDG_ASSERT_NEVER(a_no_accept_in_clear, aclk, aresetn, accept && !clr_done_reg, "beat accepted during line RAM clear")

endmodule

// File: rtl/fdg_queue.sv
// Short FIFO of interior windows between front and back.
`include "finite_difference_gradient_stencil_defines.svh"
module fdg_queue
    import fdg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fdg_item_t          push_item,
    input  logic               pop,
    output logic               head_valid,
    output fdg_item_t          head_item,
    output logic [Q_CNT_W-1:0] count
);

    fdg_item_t          mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    `FDG_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && !pop && (count_reg == Q_CNT_W'(Q_DEPTH)), "push into full queue")
    `FDG_ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && (count_reg == '0), "pop from empty queue")

endmodule

// File: rtl/fdg_back.sv
// Back end: differences, split multiply by inverse spacing, floor and saturate.
module fdg_back
    import fdg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [INV_W-1:0] inv_dx,
    input  logic [INV_W-1:0] inv_dy,
    input  logic             head_valid,
    input  fdg_item_t        head_item,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, m_tvalid_reg;
    logic                     last1_reg, last2_reg, last3_reg, last4_reg, m_tlast_reg;
    logic signed [DIFF_W-1:0] diff_reg [N_TERMS];
    logic [DIFF_W-1:0]        mag_reg [N_TERMS];
    logic [N_TERMS-1:0]       neg2_reg, neg3_reg, neg4_reg;
    logic [PROD_W-1:0]        lo_reg [N_TERMS];
    logic [PROD_W-1:0]        hi_reg [N_TERMS];
    logic [ACC_W-1:0]         acc_reg [N_TERMS];
    logic [N_TERMS-1:0]       stk_reg;
    logic [OUT_W-1:0]         m_tdata_reg;

    logic                     en;
    logic signed [DIFF_W-1:0] diff_next [N_TERMS];
    logic signed [DIFF_W-1:0] pc, pn, ps, pe, pw, pne, pnw, pse, psw;
    logic [INV_W-1:0]         inv_sel [N_TERMS];

    assign en  = !m_tvalid_reg || m_tready;
    assign pop = en && head_valid;

    always_comb begin
        pc  = fdg_sext(head_item.win[1][1]);
        pn  = fdg_sext(head_item.win[2][1]);
        ps  = fdg_sext(head_item.win[0][1]);
        pe  = fdg_sext(head_item.win[1][2]);
        pw  = fdg_sext(head_item.win[1][0]);
        pne = fdg_sext(head_item.win[2][2]);
        pnw = fdg_sext(head_item.win[2][0]);
        pse = fdg_sext(head_item.win[0][2]);
        psw = fdg_sext(head_item.win[0][0]);
        diff_next[0] = pn - pc;
        diff_next[1] = pc - ps;
        diff_next[2] = pe - pc;
        diff_next[3] = pc - pw;
        diff_next[4] = pn - ps;
        diff_next[5] = pe - pw;
        diff_next[6] = (pn + pne) - (ps + pse);
        diff_next[7] = (pn + pnw) - (ps + psw);
        diff_next[8] = (pe + pne) - (pw + pnw);
        diff_next[9] = (pe + pse) - (pw + psw);
        for (int i = 0; i < N_TERMS; i++) begin
            inv_sel[i] = TERM_USE_DY[i] ? inv_dy : inv_dx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= head_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            m_tvalid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last1_reg   <= head_item.last;
            last2_reg   <= last1_reg;
            last3_reg   <= last2_reg;
            last4_reg   <= last3_reg;
            m_tlast_reg <= last4_reg;
            neg3_reg    <= neg2_reg;
            neg4_reg    <= neg3_reg;
            for (int i = 0; i < N_TERMS; i++) begin
                diff_reg[i] <= diff_next[i];
                neg2_reg[i] <= diff_reg[i][DIFF_W-1];
                mag_reg[i]  <= diff_reg[i][DIFF_W-1] ? (DIFF_W'(0) - diff_reg[i]) : diff_reg[i];
                lo_reg[i]   <= PROD_W'(mag_reg[i]) * PROD_W'(inv_sel[i][FRAC_W-1:0]);
                hi_reg[i]   <= PROD_W'(mag_reg[i]) * PROD_W'(inv_sel[i][INV_W-1:FRAC_W]);
                acc_reg[i]  <= ACC_W'(hi_reg[i]) + ACC_W'(lo_reg[i] >> FRAC_W);
                stk_reg[i]  <= lo_reg[i][FRAC_W-1:0] != '0;
                m_tdata_reg[i*SAMPLE_W +: SAMPLE_W] <=
                    fdg_round_sat(acc_reg[i], stk_reg[i], neg4_reg[i], TERM_K[i]);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/finite_difference_gradient_stencil.sv
// 3x3 finite-difference gradient stencil over a raster-streamed plane, Q16.16 in and out.
// One sample beat is taken per cycle while the window queue has room; the line RAM has one
// read and one write port, and s_tready drops when the four-entry window queue, counting
// the beat one stage ahead of it, is full. A result passes the front's s1 registers, the
// queue and the back end's difference, magnitude, product, accumulate and output registers.
// After reset the line RAM is cleared, during which s_tready is low; configuration writes
// are taken at any time.
module finite_difference_gradient_stencil
    import fdg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // dx_forward, dx_backward, dy_forward,
                                             // dy_backward, dx_central, dy_central,
                                             // dx_at_upper_face, dx_at_lower_face,
                                             // dy_at_right_face, dy_at_left_face
    output logic                  m_tlast    // last_point
);

    logic [NUM_COLS_W-1:0] num_cols_reg;
    logic [NUM_ROWS_W-1:0] num_rows_reg;
    logic [INV_W-1:0]      inv_dx_reg;
    logic [INV_W-1:0]      inv_dy_reg;

    logic                  push_valid;
    fdg_item_t             push_item;
    logic                  pop;
    logic                  head_valid;
    fdg_item_t             head_item;
    logic [Q_CNT_W-1:0]    q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= NUM_COLS_RST;
            num_rows_reg <= NUM_ROWS_RST;
            inv_dx_reg   <= INV_RST;
            inv_dy_reg   <= INV_RST;
        end else if (cfg_wr_en) begin
            unique case (fdg_reg_t'(cfg_index))
                REG_NUM_COLS: num_cols_reg <= cfg_wdata[NUM_COLS_W-1:0];
                REG_NUM_ROWS: num_rows_reg <= cfg_wdata[NUM_ROWS_W-1:0];
                REG_INV_DX:   inv_dx_reg   <= cfg_wdata[INV_W-1:0];
                REG_INV_DY:   inv_dy_reg   <= cfg_wdata[INV_W-1:0];
                default:      ;
            endcase
        end
    end

    fdg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .num_cols   (num_cols_reg),
        .num_rows   (num_rows_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    fdg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    fdg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .inv_dx     (inv_dx_reg),
        .inv_dy     (inv_dy_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
